// ===== rtl/cbms_pkg.sv =====
// cbms_pkg: shared types, codes and constants of the cell balance mask select block
// used by every module under rtl; depends on nothing
package cbms_pkg;

  // default configuration of the chain
  localparam int NUM_CELLS_DEF  = 96;
  localparam int NUM_PHASES_DEF = 3;

  // field widths
  localparam int MV_W      = 13;
  localparam int LIMIT_W   = MV_W + 1;
  localparam int IDX_W     = 7;
  localparam int CELL_ID_W = 9;
  localparam int PER_W     = 16;
  localparam int ELAPSED_W = 17;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // mask layout
  localparam int WORD_W     = 32;
  localparam int MASK_WORDS = 3;
  localparam int MASK_BITS  = WORD_W * MASK_WORDS;

  // register reset values
  localparam logic [MV_W-1:0]  THRESHOLD_RST = 13'd180;
  localparam logic [PER_W-1:0] PERIOD_RST    = 16'd30000;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_PERIOD    = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIN,
    ST_MASK,
    ST_OUT
  } state_t;

  typedef enum logic {
    MODE_MIN,
    MODE_MASK
  } mode_t;

  // token that walks down the chain of cells
  typedef struct packed {
    logic                go;
    mode_t               mode;
    logic                found;
    logic [MV_W-1:0]     low;
    logic [LIMIT_W-1:0]  limit;
    logic [PHASE_W-1:0]  phase;
  } link_t;

  // store write broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [MV_W-1:0]  mv;
  } wr_t;

endpackage

// ===== rtl/cbms_cell.sv =====
// cbms_cell: one cell of the chain, holds one cell voltage and its bleed bit
// depends on cbms_pkg
module cbms_cell
  import cbms_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int NUM_PHASES = NUM_PHASES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  wr_t   wr,
  input  link_t link_in,
  output link_t link_out,
  output logic  bleed
);

  localparam logic [CELL_ID_W-1:0] MY_ID    = CELL_ID_W'(IDX);
  localparam logic [PHASE_W-1:0]   MY_PHASE = PHASE_W'(IDX % NUM_PHASES);

  logic [MV_W-1:0] volts;
  link_t           link_next;
  logic            bleed_next;
  logic            nz;

  assign nz = (volts != '0);

  always_comb begin
    link_next  = link_in;
    bleed_next = bleed;
    if (link_in.go) begin
      if (link_in.mode == MODE_MIN) begin
        if (nz && (!link_in.found || (volts < link_in.low))) begin
          link_next.low = volts;
        end
        link_next.found = link_in.found | nz;
      end else begin
        bleed_next = nz && ({1'b0, volts} >= link_in.limit) && (MY_PHASE == link_in.phase);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volts    <= '0;
      link_out <= '0;
      bleed    <= 1'b0;
    end else begin
      if (wr.en && ({{(CELL_ID_W-IDX_W){1'b0}}, wr.idx} == MY_ID)) begin
        volts <= wr.mv;
      end
      link_out <= link_next;
      bleed    <= bleed_next;
    end
  end

endmodule

// ===== rtl/cbms_ctrl.sv =====
// cbms_ctrl: sequencer, configuration registers, elapsed counter, phase and output words
// depends on cbms_pkg; drives the head of the cell chain and reads its tail
module cbms_ctrl
  import cbms_pkg::*;
#(
  parameter int NUM_PHASES = NUM_PHASES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [IDX_W-1:0]     cell_index,
  input  logic [MV_W-1:0]      cell_mv,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    mask_word,
  output logic [1:0]           word_index,
  output logic [MV_W-1:0]      lowest_mv,
  output logic                 no_valid_cell,
  output logic [1:0]           phase,
  output logic                 any_active,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output wr_t                  wr,
  output link_t                head,
  input  link_t                tail,
  input  logic [MASK_BITS-1:0] mask
);

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(NUM_PHASES - 1);
  localparam logic [1:0]         WORD_LAST  = 2'(MASK_WORDS - 1);

  state_t                 state, state_next;
  logic [MV_W-1:0]        threshold;
  logic [PER_W-1:0]       period;
  logic [ELAPSED_W-1:0]   elapsed_ms;
  logic [PHASE_W-1:0]     bleed_phase;
  logic [MV_W-1:0]        lowest;
  logic                   found;
  logic [1:0]             word_cnt;
  logic                   in_acc;
  logic                   out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign wr.en  = in_acc && (cmd == CMD_STORE);
  assign wr.idx = cell_index;
  assign wr.mv  = cell_mv;

  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && (cmd == CMD_EVAL)) state_next = ST_MIN;
      ST_MIN:  if (tail.go) state_next = ST_MASK;
      ST_MASK: if (tail.go) state_next = ST_OUT;
      ST_OUT:  if (out_acc && (word_cnt == WORD_LAST)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    head      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (cmd == CMD_EVAL)) begin
          head.go   = 1'b1;
          head.mode = MODE_MIN;
        end
      end
      ST_MIN: begin
        if (tail.go) begin
          head.go    = 1'b1;
          head.mode  = MODE_MASK;
          head.found = tail.found;
          head.low   = tail.low;
          head.limit = {1'b0, tail.low} + {1'b0, threshold};
          head.phase = bleed_phase;
        end
      end
      ST_MASK: ;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      threshold   <= THRESHOLD_RST;
      period      <= PERIOD_RST;
      elapsed_ms  <= '0;
      bleed_phase <= '0;
      word_cnt    <= '0;
      found       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_THRESHOLD: threshold <= cfg_data[MV_W-1:0];
          REG_PERIOD:    period    <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (cmd)
          CMD_TICK: if (elapsed_ms != '1) elapsed_ms <= elapsed_ms + 1'b1;
          CMD_EVAL: begin
            if (elapsed_ms > {1'b0, period}) begin
              bleed_phase <= (bleed_phase == PHASE_LAST) ? '0 : bleed_phase + 1'b1;
              elapsed_ms  <= '0;
            end
          end
          default: ;
        endcase
      end
      if ((state == ST_MIN) && tail.go) begin
        lowest <= tail.low;
        found  <= tail.found;
      end
      if ((state == ST_MASK) && tail.go) word_cnt <= '0;
      else if (out_acc) word_cnt <= word_cnt + 1'b1;
    end
  end

  always_comb begin
    case (word_cnt)
      2'd0:    mask_word = mask[WORD_W-1:0];
      2'd1:    mask_word = mask[2*WORD_W-1:WORD_W];
      default: mask_word = mask[3*WORD_W-1:2*WORD_W];
    endcase
  end

  assign word_index    = word_cnt;
  assign lowest_mv     = lowest;
  assign no_valid_cell = !found;
  assign phase         = bleed_phase[1:0];
  assign any_active    = |mask;
  assign last          = (word_cnt == WORD_LAST);

endmodule

// ===== rtl/cell_balance_mask_select_core.sv =====
// cell_balance_mask_select_core: top level, sequencer plus a chain of voltage cells
// depends on cbms_pkg, cbms_ctrl and cbms_cell
//
//   channel | signals                               | carries
//   --------+---------------------------------------+--------------------------------
//   in      | in_valid in_ready cmd cell_index ...  | store / tick / evaluate word
//   out     | out_valid out_ready mask_word ...     | three mask words per evaluate
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write word
//
// store and tick words are taken while the sequencer is idle
// an evaluate word makes two token walks in the chain (one for the
// minimum, one for the mask, a cell per cycle) and then three output words
// no input word is taken until the third mask word has gone out
// a stalled output word holds; configuration writes are taken every cycle
// reset (synchronous, rst high) empties every cell at once, threshold 180, period 30000
module cell_balance_mask_select_core
  import cbms_pkg::*;
#(
  parameter int NUM_CELLS  = NUM_CELLS_DEF,
  parameter int NUM_PHASES = NUM_PHASES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [IDX_W-1:0]     cell_index,
  input  logic [MV_W-1:0]      cell_mv,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    mask_word,
  output logic [1:0]           word_index,
  output logic [MV_W-1:0]      lowest_mv,
  output logic                 no_valid_cell,
  output logic [1:0]           phase,
  output logic                 any_active,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  wr_t                    wr;
  link_t                  links [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]   bleed;
  logic [MASK_BITS-1:0]   mask;

  // sequencer, registers and output words
  cbms_ctrl #(
    .NUM_PHASES(NUM_PHASES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .cell_index   (cell_index),
    .cell_mv      (cell_mv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mask_word    (mask_word),
    .word_index   (word_index),
    .lowest_mv    (lowest_mv),
    .no_valid_cell(no_valid_cell),
    .phase        (phase),
    .any_active   (any_active),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .wr           (wr),
    .head         (links[0]),
    .tail         (links[NUM_CELLS]),
    .mask         (mask)
  );

  // chain of cells, the token steps one cell per cycle
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    cbms_cell #(
      .IDX       (c),
      .NUM_PHASES(NUM_PHASES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .link_in (links[c]),
      .link_out(links[c+1]),
      .bleed   (bleed[c])
    );
  end

  // only the first three words' worth of cells reach the mask
  for (genvar b = 0; b < MASK_BITS; b++) begin : g_mask
    if (b < NUM_CELLS) begin : g_bit
      assign mask[b] = bleed[b];
    end else begin : g_zero
      assign mask[b] = 1'b0;
    end
  end

endmodule

// ===== rtl/cbms_checker.sv =====
// cbms_checker: port level assertions for the cell balance mask select block
// depends on cbms_pkg; bound to cell_balance_mask_select_core
module cbms_checker
  import cbms_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           cmd,
  input logic [IDX_W-1:0]     cell_index,
  input logic [MV_W-1:0]      cell_mv,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_W-1:0]    mask_word,
  input logic [1:0]           word_index,
  input logic [MV_W-1:0]      lowest_mv,
  input logic                 no_valid_cell,
  input logic [1:0]           phase,
  input logic                 any_active,
  input logic                 last,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mask_word) && $stable(word_index))
    else $error("stalled output word changed");

  // no input taken while mask words are pending
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while output pending");

  // words of one evaluation follow in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && (word_index == 2'($past(word_index) + 2'd1)))
    else $error("mask word sequence broken");

  // empty store gives empty mask and zero lowest
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_valid_cell |-> (mask_word == '0) && (lowest_mv == '0) && !any_active)
    else $error("empty store with nonzero result");

  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mask_word != '0) |-> any_active)
    else $error("mask bit set without any_active");

endmodule

bind cell_balance_mask_select_core cbms_checker u_cbms_checker (.*);
